// ===== src/mqttpd_pkg.sv =====
// Package with the phase, kind and status codes and the result layout of the PUBLISH deframer.
package mqttpd_pkg;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_TLEN_HI,
      PH_TLEN_LO,
      PH_TOPIC,
      PH_MSG
   } phase_type;

   // Kind of each passed byte.
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_TOPIC   = 2'd1,
      KIND_MESSAGE = 2'd2
   } kind_type;

   // Status reported with each byte.
   typedef enum logic [1:0] {
      ST_BUSY        = 2'd0,
      ST_COMPLETE    = 2'd1,
      ST_NOT_PUBLISH = 2'd2,
      ST_MALFORMED   = 2'd3
   } status_type;

   // First byte of a QoS 0 PUBLISH with no flags.
   localparam logic [7:0] PUBLISH_HEADER = 8'h30;

   localparam int LEN_W   = 28;
   localparam int TDATA_W = 40;

   // One result item as held in the output registers.
   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] msg_len;
      logic             field_last;
      kind_type         kind;
      logic [7:0]       data;
   } result_type;

endpackage

// ===== src/mqtt_publish_deframer.sv =====
// Byte-serial deframer for MQTT 3.1.1 QoS 0 PUBLISH packets with a two-entry result buffer.
//
// Usage:
//   The req_ channel carries one received byte per transfer in req_tdata, and
//   req_tuser high marks the first byte of a packet, which restarts the parser
//   in any phase. The rsp_ channel returns exactly one result per input byte:
//   the byte itself when it belongs to the topic or message (rsp_tuser gives
//   the kind), rsp_tlast on the last byte of either field, the message length
//   once the topic length is known, and a status code (complete, not a
//   publish packet, malformed length).
//   Results are registered: an accepted byte's result goes to the output register
//   at rsp_, or to the skid register while the output is held. Throughput is one byte
//   per cycle while req_tready is high; the per-byte phase and counter update is the only loop.
//   A skid register behind the output register lets the block take one more
//   byte while the receiver stalls; req_tready drops only while both are
//   full, and no result is lost or repeated.
//   Reset returns the parser to idle, clears its counters and empties both
//   result registers; bytes without a start marker are then discarded.
module mqtt_publish_deframer #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  logic        req_tuser,  // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [35:8] message_length, [37:36] status
   output logic [mqttpd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // [1:0] byte_kind
   output logic        rsp_tlast   // field_last
);

   localparam int LW = mqttpd_pkg::LEN_W;

   // Parser state.
   mqttpd_pkg::phase_type phase_ff, phase_in;
   logic [LW-1:0] acc_ff, acc_in;
   logic [2:0]    count_ff, count_in;
   logic [7:0]    tlen_hi_ff, tlen_hi_in;
   logic [15:0]   topic_left_ff, topic_left_in;
   logic [LW-1:0] msg_left_ff, msg_left_in;
   logic [LW-1:0] mlen_ff, mlen_in;

   // Output and skid registers.
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   mqttpd_pkg::result_type out_ff, out_in;
   mqttpd_pkg::result_type skid_ff, skid_in;
   mqttpd_pkg::result_type res;

   logic          accept;
   logic          start;
   logic [7:0]    rx;
   logic [LW-1:0] len_add;
   logic          len_overflow;
   logic [15:0]   tlen_new;
   logic [16:0]   tlen_plus2;
   logic          short_pkt;
   logic [LW-1:0] mlen_calc;
   logic          topic_done;
   logic          msg_done;

   assign accept = req_tvalid && req_tready;
   assign start  = req_tuser;
   assign rx     = req_tdata;

   // Seven-bit group placed by its position in the remaining-length field.
   always_comb begin
      case (count_ff[1:0])
         2'd0:    len_add = {21'b0, rx[6:0]};
         2'd1:    len_add = {14'b0, rx[6:0], 7'b0};
         2'd2:    len_add = {7'b0, rx[6:0], 14'b0};
         2'd3:    len_add = {rx[6:0], 21'b0};
         default: len_add = {21'b0, rx[6:0]};
      endcase
   end

   assign len_overflow = ({1'b0, count_ff} + 4'd1) >= 4'(MAX_LENGTH_BYTES);
   assign tlen_new     = {tlen_hi_ff, rx};
   assign tlen_plus2   = {1'b0, tlen_new} + 17'd2;
   assign short_pkt    = acc_ff < {11'b0, tlen_plus2};
   assign mlen_calc    = acc_ff - {12'b0, tlen_new} - 28'd2;
   assign topic_done   = topic_left_ff == 16'd1;
   assign msg_done     = msg_left_ff == 28'd1;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         phase_in = (rx == mqttpd_pkg::PUBLISH_HEADER) ? mqttpd_pkg::PH_LEN
                                                        : mqttpd_pkg::PH_IDLE;
      end else begin
         case (phase_ff)
            mqttpd_pkg::PH_IDLE: phase_in = mqttpd_pkg::PH_IDLE;
            mqttpd_pkg::PH_LEN: begin
               if (!rx[7]) begin
                  phase_in = mqttpd_pkg::PH_TLEN_HI;
               end else if (len_overflow) begin
                  phase_in = mqttpd_pkg::PH_IDLE;
               end
            end
            mqttpd_pkg::PH_TLEN_HI: phase_in = mqttpd_pkg::PH_TLEN_LO;
            mqttpd_pkg::PH_TLEN_LO: begin
               if (short_pkt) begin
                  phase_in = mqttpd_pkg::PH_IDLE;
               end else if (tlen_new != 16'd0) begin
                  phase_in = mqttpd_pkg::PH_TOPIC;
               end else if (mlen_calc != '0) begin
                  phase_in = mqttpd_pkg::PH_MSG;
               end else begin
                  phase_in = mqttpd_pkg::PH_IDLE;
               end
            end
            mqttpd_pkg::PH_TOPIC: begin
               if (topic_done) begin
                  phase_in = (msg_left_ff != '0) ? mqttpd_pkg::PH_MSG : mqttpd_pkg::PH_IDLE;
               end
            end
            mqttpd_pkg::PH_MSG: begin
               if (msg_done) begin
                  phase_in = mqttpd_pkg::PH_IDLE;
               end
            end
            default: phase_in = mqttpd_pkg::PH_IDLE;
         endcase
      end
   end

   // Length accumulator and field counters.
   always_comb begin
      acc_in        = acc_ff;
      count_in      = count_ff;
      tlen_hi_in    = tlen_hi_ff;
      topic_left_in = topic_left_ff;
      msg_left_in   = msg_left_ff;
      mlen_in       = mlen_ff;
      if (start) begin
         acc_in        = '0;
         count_in      = '0;
         tlen_hi_in    = '0;
         topic_left_in = '0;
         msg_left_in   = '0;
      end else begin
         case (phase_ff)
            mqttpd_pkg::PH_LEN: begin
               acc_in   = acc_ff + len_add;
               count_in = count_ff + 3'd1;
            end
            mqttpd_pkg::PH_TLEN_HI: tlen_hi_in = rx;
            mqttpd_pkg::PH_TLEN_LO: begin
               if (!short_pkt) begin
                  topic_left_in = tlen_new;
                  msg_left_in   = mlen_calc;
                  mlen_in       = mlen_calc;
               end
            end
            mqttpd_pkg::PH_TOPIC: topic_left_in = topic_left_ff - 16'd1;
            mqttpd_pkg::PH_MSG:   msg_left_in = msg_left_ff - 28'd1;
            default: ;
         endcase
      end
   end

   // Result for the byte at the input.
   always_comb begin
      res            = '0;
      res.kind       = mqttpd_pkg::KIND_NONE;
      res.status     = mqttpd_pkg::ST_BUSY;
      if (start) begin
         if (rx != mqttpd_pkg::PUBLISH_HEADER) begin
            res.status = mqttpd_pkg::ST_NOT_PUBLISH;
         end
      end else begin
         case (phase_ff)
            mqttpd_pkg::PH_LEN: begin
               if (rx[7] && len_overflow) begin
                  res.status = mqttpd_pkg::ST_MALFORMED;
               end
            end
            mqttpd_pkg::PH_TLEN_LO: begin
               if (short_pkt) begin
                  res.status = mqttpd_pkg::ST_MALFORMED;
               end else begin
                  res.msg_len = mlen_calc;
                  if (tlen_new == 16'd0 && mlen_calc == '0) begin
                     res.status = mqttpd_pkg::ST_COMPLETE;
                  end
               end
            end
            mqttpd_pkg::PH_TOPIC: begin
               res.data       = rx;
               res.kind       = mqttpd_pkg::KIND_TOPIC;
               res.msg_len    = mlen_ff;
               res.field_last = topic_done;
               if (topic_done && msg_left_ff == '0) begin
                  res.status = mqttpd_pkg::ST_COMPLETE;
               end
            end
            mqttpd_pkg::PH_MSG: begin
               res.data       = rx;
               res.kind       = mqttpd_pkg::KIND_MESSAGE;
               res.msg_len    = mlen_ff;
               res.field_last = msg_done;
               if (msg_done) begin
                  res.status = mqttpd_pkg::ST_COMPLETE;
               end
            end
            default: ;
         endcase
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mqttpd_pkg::PH_IDLE;
         acc_ff        <= '0;
         count_ff      <= '0;
         tlen_hi_ff    <= '0;
         topic_left_ff <= '0;
         msg_left_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            acc_ff        <= acc_in;
            count_ff      <= count_in;
            tlen_hi_ff    <= tlen_hi_in;
            topic_left_ff <= topic_left_in;
            msg_left_ff   <= msg_left_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mlen_ff <= mlen_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.status, out_ff.msg_len, out_ff.data};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.field_last;

   // The skid entry is only filled behind a held output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // The output empties only when nothing waits in the skid entry.
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(!skid_valid_ff))
      else $error("result dropped from skid entry");

   // Topic and message phases always have bytes left to pass.
   a_topic_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == mqttpd_pkg::PH_TOPIC) |-> (topic_left_ff != '0))
      else $error("topic phase with no topic bytes left");

   a_msg_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == mqttpd_pkg::PH_MSG) |-> (msg_left_ff != '0))
      else $error("message phase with no message bytes left");

   // A passed payload byte never carries an error status.
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind != mqttpd_pkg::KIND_NONE) |->
         (out_ff.status == mqttpd_pkg::ST_BUSY || out_ff.status == mqttpd_pkg::ST_COMPLETE))
      else $error("payload byte reported with error status");

endmodule

// ===== tb/sv/tb_mqtt_publish_deframer.sv =====
// Self-checking testbench for the MQTT PUBLISH deframer: table-driven and random packets.
`timescale 1ns / 1ps

module tb_mqtt_publish_deframer;

   localparam int MAX_LEN_BYTES = 4;
   localparam int BYTE_TARGET   = 450;
   localparam int N_DIRECTED    = 28;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // One row of the directed table; the status is only used when typed is set, and
   // a typed row expects every other result field to be zero.
   typedef struct packed {
      logic                   rx_byte;
      logic                   start;
      logic                   typed;
      mqttpd_pkg::status_type status;
   } stim_row_bits_type;

   typedef struct packed {
      logic [7:0]             rx;
      logic                   start;
      logic                   typed;
      mqttpd_pkg::status_type status;
   } stim_row_type;

   stim_row_type directed_rows [N_DIRECTED] = '{
      // A byte with no packet open after reset, then a wrong first byte.
      '{8'h55, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h31, 1'b1, 1'b1, mqttpd_pkg::ST_NOT_PUBLISH},
      // The length still continues on the last allowed length byte.
      '{8'h30, 1'b1, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'hFF, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h80, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h80, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h80, 1'b0, 1'b1, mqttpd_pkg::ST_MALFORMED},
      // Remaining length too short for the largest topic length.
      '{8'h30, 1'b1, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h02, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'hFF, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'hFF, 1'b0, 1'b1, mqttpd_pkg::ST_MALFORMED},
      // Both fields empty: the packet ends on the second topic-length byte.
      '{8'h30, 1'b1, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h02, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h00, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY},
      '{8'h00, 1'b0, 1'b1, mqttpd_pkg::ST_COMPLETE},
      // One topic byte and one message byte.
      '{8'h30, 1'b1, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h04, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h00, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h01, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h61, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'hFF, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      // Restart inside the length, then an empty topic and a one-byte message.
      '{8'h30, 1'b1, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h30, 1'b1, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h03, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h00, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'h00, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      '{8'hA5, 1'b0, 1'b0, mqttpd_pkg::ST_BUSY},
      // A byte after completion is discarded.
      '{8'h12, 1'b0, 1'b1, mqttpd_pkg::ST_BUSY}
   };

   // Parser state as this testbench tracks it.
   mqttpd_pkg::phase_type pkt_phase    = mqttpd_pkg::PH_IDLE;
   logic [27:0]           len_total    = '0;
   logic [2:0]            len_bytes    = '0;
   logic [15:0]           topic_len    = '0;
   logic [15:0]           topic_left   = '0;
   logic [27:0]           message_left = '0;

   mqttpd_pkg::result_type predicted_results [$];
   int         fault_count  = 0;
   int         result_index = 0;
   int         useful_bytes = 0;
   int         sender_idle_pct    = 0;
   int         receiver_stall_pct = 0;

   mqtt_publish_deframer #(
      .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Advances the parser state by one byte and returns the result it produces.
   function automatic mqttpd_pkg::result_type deframe_byte(input logic [7:0] rx,
                                                           input logic start);
      mqttpd_pkg::result_type r;
      logic [31:0]            group;
      logic [27:0]            body_len;
      r = '0;
      body_len = len_total - {12'd0, topic_len} - 28'd2;
      if (start) begin
         len_total    = '0;
         len_bytes    = '0;
         topic_len    = '0;
         topic_left   = '0;
         message_left = '0;
         if (rx == mqttpd_pkg::PUBLISH_HEADER) begin
            pkt_phase = mqttpd_pkg::PH_LEN;
         end else begin
            pkt_phase = mqttpd_pkg::PH_IDLE;
            r.status  = mqttpd_pkg::ST_NOT_PUBLISH;
         end
      end else begin
         case (pkt_phase)
            mqttpd_pkg::PH_LEN: begin
               // Seven bits per length byte, least significant group first.
               group     = {25'd0, rx[6:0]} << (7 * len_bytes[1:0]);
               len_total = len_total + group[27:0];
               len_bytes = len_bytes + 3'd1;
               if (!rx[7]) begin
                  pkt_phase = mqttpd_pkg::PH_TLEN_HI;
               end else if (len_bytes >= MAX_LEN_BYTES) begin
                  pkt_phase = mqttpd_pkg::PH_IDLE;
                  r.status  = mqttpd_pkg::ST_MALFORMED;
               end
            end
            mqttpd_pkg::PH_TLEN_HI: begin
               topic_len = {rx, 8'h00};
               pkt_phase = mqttpd_pkg::PH_TLEN_LO;
            end
            mqttpd_pkg::PH_TLEN_LO: begin
               topic_len[7:0] = rx;
               if ({4'd0, len_total} < {16'd0, topic_len} + 32'd2) begin
                  pkt_phase = mqttpd_pkg::PH_IDLE;
                  r.status  = mqttpd_pkg::ST_MALFORMED;
               end else begin
                  body_len     = len_total - {12'd0, topic_len} - 28'd2;
                  r.msg_len    = body_len;
                  topic_left   = topic_len;
                  message_left = body_len;
                  if (topic_left != 0) begin
                     pkt_phase = mqttpd_pkg::PH_TOPIC;
                  end else if (message_left != 0) begin
                     pkt_phase = mqttpd_pkg::PH_MSG;
                  end else begin
                     pkt_phase = mqttpd_pkg::PH_IDLE;
                     r.status  = mqttpd_pkg::ST_COMPLETE;
                  end
               end
            end
            mqttpd_pkg::PH_TOPIC: begin
               r.msg_len  = body_len;
               r.data     = rx;
               r.kind     = mqttpd_pkg::KIND_TOPIC;
               topic_left = topic_left - 16'd1;
               if (topic_left == 0) begin
                  r.field_last = 1'b1;
                  if (message_left != 0) begin
                     pkt_phase = mqttpd_pkg::PH_MSG;
                  end else begin
                     pkt_phase = mqttpd_pkg::PH_IDLE;
                     r.status  = mqttpd_pkg::ST_COMPLETE;
                  end
               end
            end
            mqttpd_pkg::PH_MSG: begin
               r.msg_len    = body_len;
               r.data       = rx;
               r.kind       = mqttpd_pkg::KIND_MESSAGE;
               message_left = message_left - 28'd1;
               if (message_left == 0) begin
                  r.field_last = 1'b1;
                  pkt_phase    = mqttpd_pkg::PH_IDLE;
                  r.status     = mqttpd_pkg::ST_COMPLETE;
               end
            end
            default: begin
               pkt_phase = mqttpd_pkg::PH_IDLE;
            end
         endcase
      end
      return r;
   endfunction

   // Offers one byte, waits for its transfer and queues the result it should cause.
   task automatic send_byte(input logic [7:0] rx, input logic start, input logic typed,
                            input mqttpd_pkg::status_type typed_status);
      mqttpd_pkg::result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      if (start || pkt_phase != mqttpd_pkg::PH_IDLE) useful_bytes++;
      predicted = deframe_byte(rx, start);
      if (typed) predicted = '{typed_status, 28'd0, 1'b0, mqttpd_pkg::KIND_NONE, 8'h00};
      predicted_results.push_back(predicted);
   endtask

   // Holds the sender back until every queued result has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   // Builds one random packet: mostly well-formed, otherwise truncated by the next
   // start, short, with too many length bytes, with a wrong first byte, or plain noise.
   task automatic send_random_packet();
      logic [7:0] pkt [$];
      int         form;
      int         topic_n;
      int         message_n;
      int         remaining;
      int         groups;
      logic [7:0] first;
      form      = $urandom_range(99);
      topic_n   = 0;
      message_n = 0;
      remaining = 0;
      if (form >= 96) begin
         repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(255)), $urandom_range(4) == 0, 1'b0,
                      mqttpd_pkg::ST_BUSY);
         end
         return;
      end
      if (form >= 92) begin
         first = 8'($urandom_range(255));
         if (first == mqttpd_pkg::PUBLISH_HEADER) first = ~first;
         pkt.push_back(first);
         repeat ($urandom_range(3)) pkt.push_back(8'($urandom_range(255)));
      end else if (form >= 88) begin
         pkt.push_back(mqttpd_pkg::PUBLISH_HEADER);
         repeat (MAX_LEN_BYTES) pkt.push_back(8'h80 | 8'($urandom_range(127)));
         repeat ($urandom_range(2)) pkt.push_back(8'($urandom_range(255)));
      end else begin
         pkt.push_back(mqttpd_pkg::PUBLISH_HEADER);
         if (form < 70) begin
            topic_n   = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(6);
            message_n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(12);
            remaining = topic_n + message_n + 2;
         end else if (form < 80) begin
            remaining = $urandom_range(28'hFFFFFFF);
            topic_n   = $urandom_range(8);
         end else begin
            remaining = $urandom_range(5);
            topic_n   = $urandom_range(1) ? $urandom_range(65535) : remaining;
         end
         // Shortest length encoding, sometimes padded with zero groups.
         groups = 1;
         while (groups < MAX_LEN_BYTES && (remaining >> (7 * groups)) != 0) groups++;
         if ($urandom_range(5) == 0) groups = $urandom_range(groups, MAX_LEN_BYTES);
         for (int i = 0; i < groups; i++) begin
            pkt.push_back({i < groups - 1, 7'((remaining >> (7 * i)) & 127)});
         end
         pkt.push_back(8'(topic_n >> 8));
         pkt.push_back(8'(topic_n));
         if (form < 70) begin
            repeat (topic_n + message_n) pkt.push_back(8'($urandom_range(255)));
            if ($urandom_range(9) == 0) pkt.push_back(8'($urandom_range(255)));
         end else if (form < 80) begin
            repeat ($urandom_range(12)) pkt.push_back(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(2)) pkt.push_back(8'($urandom_range(255)));
         end
      end
      for (int i = 0; i < pkt.size(); i++) begin
         send_byte(pkt[i], i == 0, 1'b0, mqttpd_pkg::ST_BUSY);
      end
   endtask

   // Compares one result transfer with the oldest queued result.
   task automatic check_result();
      mqttpd_pkg::result_type want;
      mqttpd_pkg::result_type got;
      got.data       = rsp_tdata[7:0];
      got.msg_len    = rsp_tdata[35:8];
      got.status     = mqttpd_pkg::status_type'(rsp_tdata[37:36]);
      got.field_last = rsp_tlast;
      got.kind       = mqttpd_pkg::kind_type'(rsp_tuser);
      if (predicted_results.size() == 0) begin
         if (fault_count < 10) begin
            $display("result %0d arrived with none expected:", result_index);
            $display("   data %h kind %0d last %b len %0d status %0d",
                     got.data, got.kind, got.field_last, got.msg_len, got.status);
         end
         fault_count++;
      end else begin
         want = predicted_results.pop_front();
         if (got !== want || rsp_tdata[39:38] !== 2'b00) begin
            if (fault_count < 10) begin
               $display("result %0d: expected data %h kind %0d last %b len %0d status %0d",
                        result_index, want.data, want.kind, want.field_last, want.msg_len,
                        want.status);
               $display("result %0d: got data %h kind %0d last %b len %0d status %0d pad %b",
                        result_index, got.data, got.kind, got.field_last, got.msg_len,
                        got.status, rsp_tdata[39:38]);
            end
            fault_count++;
         end
      end
      result_index++;
   endtask

   // Result side: random stalls and a check on every transfer.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) check_result();
   end

   // Main sequence: reset, directed table, then random packets under four idling plans.
   initial begin
      int idle_plan  [4];
      int stall_plan [4];
      int random_base;
      idle_plan  = '{0, 68, 0, 22};
      stall_plan = '{0, 0, 68, 22};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < N_DIRECTED; k++) begin
         send_byte(directed_rows[k].rx, directed_rows[k].start, directed_rows[k].typed,
                   directed_rows[k].status);
      end
      drain_results();

      random_base = useful_bytes;
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = idle_plan[p];
         receiver_stall_pct = stall_plan[p];
         while (useful_bytes - random_base < BYTE_TARGET * (p + 1) / 4) send_random_packet();
         drain_results();
      end

      // Let any stray result show up before the verdict.
      repeat (8) @(posedge clock);
      if (fault_count == 0 && predicted_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== mqtt_publish_deframer.f =====
src/mqttpd_pkg.sv
src/mqtt_publish_deframer.sv
tb/sv/tb_mqtt_publish_deframer.sv
